@@ hdl/bootloader_frame_checker_macros.svh @@
// Assertion macros for the bootloader frame checker.
`ifndef BOOTLOADER_FRAME_CHECKER_MACROS_SVH
`define BOOTLOADER_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked on every clock edge outside reset.
`define BFC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bfc assertion failed");

// Same-cycle implication.
`define BFC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfc assertion failed");

// Next-cycle implication.
`define BFC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfc assertion failed");

`else

`define BFC_ASSERT(name, prop)
`define BFC_ASSERT_IMPL(name, ante, cons)
`define BFC_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ hdl/bfc_pkg.sv @@
// Shared types, constants and the CRC16-Modbus byte update for the frame checker.
package bfc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 256;

  localparam logic [16:0] MIN_FRAME   = 17'd10;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [31:0] END_ADDRESS = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [7:0]  PAD_BYTE    = 8'hFF;

  // Verdict codes
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_CRC  = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_START     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_END     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd3;
  localparam int unsigned CFG_DATA_W = 33;

  localparam logic [31:0] APP_START_RST     = 32'd134234112;
  localparam logic [32:0] FLASH_END_RST     = 33'd134742016;
  localparam logic [7:0]  HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'hAA;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] write_address;
    logic [63:0] write_data;
    logic [2:0]  status;
    logic        last;
  } out_t;

  // Per-frame state kept by the receive side
  typedef struct packed {
    logic [15:0] count;
    logic        hdr_bad;
    logic [15:0] length;
    logic [31:0] address;
    logic [15:0] crc;
    logic [15:0] rx_crc;
  } frame_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/bootloader_frame_checker.sv @@
// Firmware-update frame checker: the input channel takes one byte per transfer,
// frame_end set on the last byte of a frame. The output channel gives zero or more
// doubleword flash writes (result_kind 0) and then one verdict (result_kind 1, last 1).
// Configuration: cfg_valid_i/cfg_ready_o write channel, cfg_ready_o always high;
// write registers only while no frame is being finished.
// Throughput: one byte per cycle while a frame is received (CRC update and payload
// store write happen in the cycle the byte is taken). The byte with frame_end stalls
// the input until the verdict is loaded into the output register: first the
// checks, then for each doubleword the reads of the byte-wide payload RAM (lanes
// past the payload take PAD_BYTE), a wait for the read data and the load of the
// output register, then the verdict; frames with no write skip the doubleword steps.
// A stalled output holds its register and the drain waits on it; the next result
// is loaded in the cycle the pending one transfers.
// Reset clears the frame state and restores the configuration defaults; the
// payload RAM is not cleared, as only bytes of the current frame are ever read.
`include "bootloader_frame_checker_macros.svh"

module bootloader_frame_checker #(
  parameter int unsigned MAX_PAYLOAD = bfc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bfc_pkg::in_t                      in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bfc_pkg::out_t                     out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_PAYLOAD);
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 9);

  localparam logic [2:0] S_RX      = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_ISSUE   = 3'd2;
  localparam logic [2:0] S_WAIT    = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_VERDICT = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [31:0] app_start_q;
  logic [32:0] flash_end_q;
  logic [7:0]  hdr_first_q, hdr_second_q;

  logic [16:0] flen_q, flen_d;
  logic [2:0]  status_q, status_d;
  logic [CW-1:0] off_q, off_d;
  logic        cap_v_q, cap_v_d;
  logic        cap_pad_q, cap_pad_d;
  logic [2:0]  cap_lane_q, cap_lane_d;
  logic [63:0] word_q, word_d;

  logic          out_valid_q, out_valid_d;
  bfc_pkg::out_t out_q, out_d;

  bfc_pkg::frame_t frame;
  logic          in_accept;
  logic          slot_free;
  logic          out_load;
  logic          verdict_load;
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_data;
  logic          rd_en;
  logic [7:0]    rd_data;
  logic [2:0]    verdict;
  logic [32:0]   range_end;
  logic [CW-1:0] word_base;

  assign in_accept   = in_valid_i && (state_q == S_RX);
  assign in_stall_o  = (state_q != S_RX);
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_start_q  <= bfc_pkg::APP_START_RST;
      flash_end_q  <= bfc_pkg::FLASH_END_RST;
      hdr_first_q  <= bfc_pkg::HEADER_FIRST_RST;
      hdr_second_q <= bfc_pkg::HEADER_SECOND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bfc_pkg::CFG_APP_START:     app_start_q  <= cfg_data_i[31:0];
        bfc_pkg::CFG_FLASH_END:     flash_end_q  <= cfg_data_i;
        bfc_pkg::CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i[7:0];
        bfc_pkg::CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  bfc_rx #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .byte_i      (in_i.data_byte),
    .hdr_first_i (hdr_first_q),
    .hdr_second_i(hdr_second_q),
    .clear_i     (verdict_load),
    .frame_o     (frame),
    .st_we_o     (st_we),
    .st_addr_o   (st_addr),
    .st_data_o   (st_data)
  );

  // Writes only happen while receiving, reads only while draining: no overlap.
  bfc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_addr),
    .wdata_i(st_data),
    .re_i   (rd_en),
    .raddr_i(off_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  assign range_end = {1'b0, frame.address} + 33'(frame.length);

  always_comb begin
    if (flen_q < bfc_pkg::MIN_FRAME || frame.hdr_bad) begin
      verdict = bfc_pkg::ST_NONE;
    end else if (frame.length > 16'(MAX_PAYLOAD)) begin
      verdict = bfc_pkg::ST_LEN;
    end else if (flen_q < {1'b0, frame.length} + bfc_pkg::MIN_FRAME) begin
      verdict = bfc_pkg::ST_NONE;
    end else if (frame.rx_crc != frame.crc) begin
      verdict = bfc_pkg::ST_CRC;
    end else if (frame.length == 16'd0 && frame.address == bfc_pkg::END_ADDRESS) begin
      verdict = bfc_pkg::ST_DONE;
    end else if (frame.address < app_start_q || range_end > flash_end_q) begin
      verdict = bfc_pkg::ST_ADDR;
    end else begin
      verdict = bfc_pkg::ST_OK;
    end
  end

  assign rd_en     = (state_q == S_ISSUE) && (16'(off_q) < frame.length);
  assign word_base = off_q - CW'(8);

  always_comb begin
    state_d      = state_q;
    flen_d       = flen_q;
    status_d     = status_q;
    off_d        = off_q;
    cap_v_d      = 1'b0;
    cap_pad_d    = cap_pad_q;
    cap_lane_d   = cap_lane_q;
    word_d       = word_q;
    out_load     = 1'b0;
    verdict_load = 1'b0;
    out_d        = out_q;

    // Byte lands in the cycle after its read was issued
    if (cap_v_q) begin
      word_d[8*cap_lane_q +: 8] = cap_pad_q ? bfc_pkg::PAD_BYTE : rd_data;
    end

    case (state_q)
      S_RX: begin
        if (in_accept && in_i.frame_end) begin
          flen_d  = {1'b0, frame.count} + 17'd1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d = verdict;
        off_d    = '0;
        if (verdict == bfc_pkg::ST_OK && frame.length != 16'd0) begin
          state_d = S_ISSUE;
        end else begin
          state_d = S_VERDICT;
        end
      end
      S_ISSUE: begin
        cap_v_d    = 1'b1;
        cap_pad_d  = !rd_en;
        cap_lane_d = off_q[2:0];
        off_d      = off_q + CW'(1);
        if (off_q[2:0] == 3'd7) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load            = 1'b1;
          out_d.result_kind   = bfc_pkg::KIND_WRITE;
          out_d.write_address = frame.address + 32'(word_base);
          out_d.write_data    = word_q;
          out_d.status        = bfc_pkg::ST_NONE;
          out_d.last          = 1'b0;
          state_d = (16'(off_q) < frame.length) ? S_ISSUE : S_VERDICT;
        end
      end
      S_VERDICT: begin
        if (slot_free) begin
          out_load            = 1'b1;
          verdict_load        = 1'b1;
          out_d.result_kind   = bfc_pkg::KIND_VERDICT;
          out_d.write_address = '0;
          out_d.write_data    = '0;
          out_d.status        = status_q;
          out_d.last          = 1'b1;
          state_d             = S_RX;
        end
      end
      default: begin
        state_d = S_RX;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      out_valid_q <= 1'b0;
      cap_v_q     <= 1'b0;
      status_q    <= bfc_pkg::ST_NONE;
      flen_q      <= '0;
      off_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cap_v_q     <= cap_v_d;
      status_q    <= status_d;
      flen_q      <= flen_d;
      off_q       <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_pad_q  <= cap_pad_d;
    cap_lane_q <= cap_lane_d;
    word_q     <= word_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BFC_ASSERT(a_store_rw_apart, !(st_we && rd_en))
  `BFC_ASSERT_IMPL(a_drain_len_legal, state_q == S_ISSUE, frame.length <= 16'(MAX_PAYLOAD))
  `BFC_ASSERT_IMPL(a_write_only_ok, out_load && !out_d.result_kind, status_q == bfc_pkg::ST_OK)
  `BFC_ASSERT_NEXT(a_clear_after_verdict, verdict_load, frame.count == 16'd0 && state_q == S_RX)

endmodule

@@ hdl/bfc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bfc_rx.sv @@
// Receive side: header check, length and address capture, running CRC, store writes.
module bfc_rx #(
  parameter int unsigned MAX_PAYLOAD = bfc_pkg::MAX_PAYLOAD_DEF,
  localparam int unsigned AW = $clog2(MAX_PAYLOAD)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        hdr_first_i,
  input  logic [7:0]        hdr_second_i,
  input  logic              clear_i,
  output bfc_pkg::frame_t   frame_o,
  output logic              st_we_o,
  output logic [AW-1:0]     st_addr_o,
  output logic [7:0]        st_data_o
);

  logic [15:0] count_q, count_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic [15:0] len_q, len_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;

  logic [15:0] idx;
  logic [15:0] len_cur;
  logic [16:0] idx17;
  logic [16:0] crc_pos;
  logic [15:0] st_idx;
  logic        in_body;
  logic        st_hit;

  assign idx     = count_q;
  assign idx17   = {1'b0, idx};
  assign st_idx  = idx - 16'd8;

  always_comb begin
    len_cur = len_q;
    if (idx == 16'd2) begin
      len_cur[7:0] = byte_i;
    end
    if (idx == 16'd3) begin
      len_cur[15:8] = byte_i;
    end
  end

  // Position of the first received CRC byte: 8 plus payload length
  assign crc_pos = {1'b0, len_cur} + 17'd8;
  assign in_body = (idx >= 16'd2) && (idx17 < crc_pos);
  assign st_hit  = (idx >= 16'd8) && (idx17 < crc_pos) && (st_idx < 16'(MAX_PAYLOAD));

  assign st_we_o   = accept_i && !clear_i && (idx != bfc_pkg::COUNT_MAX) && st_hit;
  assign st_addr_o = st_idx[AW-1:0];
  assign st_data_o = byte_i;

  always_comb begin
    count_d   = count_q;
    hdr_bad_d = hdr_bad_q;
    len_d     = len_q;
    addr_d    = addr_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    if (clear_i) begin
      count_d   = '0;
      hdr_bad_d = 1'b0;
      len_d     = '0;
      addr_d    = '0;
      crc_d     = bfc_pkg::CRC_INIT;
      rx_crc_d  = '0;
    end else if (accept_i) begin
      if ((idx == 16'd0 && byte_i != hdr_first_i) ||
          (idx == 16'd1 && byte_i != hdr_second_i)) begin
        hdr_bad_d = 1'b1;
      end
      len_d = len_cur;
      if (idx[15:2] == 14'd1) begin
        addr_d[8*idx[1:0] +: 8] = byte_i;
      end
      // Saturated count: bytes past the limit leave the frame state alone
      if (idx != bfc_pkg::COUNT_MAX) begin
        if (in_body) begin
          crc_d = bfc_pkg::crc_feed(crc_q, byte_i);
        end
        if (idx17 == crc_pos) begin
          rx_crc_d[7:0] = byte_i;
        end
        if (idx17 == crc_pos + 17'd1) begin
          rx_crc_d[15:8] = byte_i;
        end
        count_d = idx + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      hdr_bad_q <= 1'b0;
      len_q     <= '0;
      addr_q    <= '0;
      crc_q     <= bfc_pkg::CRC_INIT;
      rx_crc_q  <= '0;
    end else begin
      count_q   <= count_d;
      hdr_bad_q <= hdr_bad_d;
      len_q     <= len_d;
      addr_q    <= addr_d;
      crc_q     <= crc_d;
      rx_crc_q  <= rx_crc_d;
    end
  end

  always_comb begin
    frame_o.count   = count_q;
    frame_o.hdr_bad = hdr_bad_q;
    frame_o.length  = len_q;
    frame_o.address = addr_q;
    frame_o.crc     = crc_q;
    frame_o.rx_crc  = rx_crc_q;
  end

endmodule

@@ verif/tb.sv @@
// Testbench for the bootloader frame checker: directed and random frames, predicted writes and verdicts.
typedef logic [7:0] byte_q_t[$];

function automatic logic [15:0] modbus_crc_step(logic [15:0] c, logic [7:0] b);
  logic [15:0] r;
  r = c;
  for (int k = 0; k < 8; k++) begin
    if (r[0] ^ b[k]) r = (r >> 1) ^ bfc_pkg::CRC_POLY;
    else r = r >> 1;
  end
  return r;
endfunction

// Tracks the frame state, predicts the writes and verdict of each frame and
// matches the output transfers against them in order.
class frame_checker_model;
  logic [31:0] app_start;
  logic [32:0] flash_end;
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;

  int unsigned count;
  bit          hdr_bad;
  logic [15:0] plen;
  logic [31:0] faddr;
  logic [15:0] crc;
  logic [15:0] rx_crc;
  logic [7:0]  payload[bfc_pkg::MAX_PAYLOAD_DEF];

  bfc_pkg::out_t pending[$];
  int unsigned errors;
  int unsigned writes;
  int unsigned bytes_taken;
  int unsigned verdicts[8];

  function new();
    app_start  = bfc_pkg::APP_START_RST;
    flash_end  = bfc_pkg::FLASH_END_RST;
    hdr_first  = bfc_pkg::HEADER_FIRST_RST;
    hdr_second = bfc_pkg::HEADER_SECOND_RST;
    foreach (payload[i]) payload[i] = '0;
    foreach (verdicts[i]) verdicts[i] = 0;
    errors = 0;
    writes = 0;
    bytes_taken = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    count   = 0;
    hdr_bad = 1'b0;
    plen    = '0;
    faddr   = '0;
    crc     = bfc_pkg::CRC_INIT;
    rx_crc  = '0;
  endfunction

  function void set_reg(logic [bfc_pkg::CFG_IDX_W-1:0] idx,
                        logic [bfc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bfc_pkg::CFG_APP_START:     app_start  = val[31:0];
      bfc_pkg::CFG_FLASH_END:     flash_end  = val;
      bfc_pkg::CFG_HEADER_FIRST:  hdr_first  = val[7:0];
      bfc_pkg::CFG_HEADER_SECOND: hdr_second = val[7:0];
      default: ;
    endcase
  endfunction

  function void take_byte(bfc_pkg::in_t it);
    int unsigned   idx, pl, flen;
    logic [7:0]    b;
    logic [2:0]    st;
    logic [63:0]   word;
    bfc_pkg::out_t r;
    idx = count;
    b   = it.data_byte;
    bytes_taken++;
    if (idx == 0 && b != hdr_first) hdr_bad = 1'b1;
    if (idx == 1 && b != hdr_second) hdr_bad = 1'b1;
    if (idx == 2) plen[7:0] = b;
    if (idx == 3) plen[15:8] = b;
    if (idx >= 4 && idx <= 7) faddr[8*(idx-4) +: 8] = b;
    pl = plen;
    // count saturates; bytes past that point only matter for frame_end
    if (idx != bfc_pkg::COUNT_MAX) begin
      if (idx >= 2 && idx <= 7 + pl) crc = modbus_crc_step(crc, b);
      if (idx >= 8 && idx < 8 + pl && idx - 8 < bfc_pkg::MAX_PAYLOAD_DEF) payload[idx-8] = b;
      if (idx == 8 + pl) rx_crc[7:0] = b;
      if (idx == 9 + pl) rx_crc[15:8] = b;
      count = idx + 1;
    end
    if (!it.frame_end) return;

    flen = idx + 1;
    if (flen < bfc_pkg::MIN_FRAME || hdr_bad) st = bfc_pkg::ST_NONE;
    else if (pl > bfc_pkg::MAX_PAYLOAD_DEF) st = bfc_pkg::ST_LEN;
    else if (flen < bfc_pkg::MIN_FRAME + pl) st = bfc_pkg::ST_NONE;
    else if (rx_crc != crc) st = bfc_pkg::ST_CRC;
    else if (pl == 0 && faddr == bfc_pkg::END_ADDRESS) st = bfc_pkg::ST_DONE;
    else if (faddr < app_start || ({1'b0, faddr} + 33'(pl)) > flash_end) st = bfc_pkg::ST_ADDR;
    else begin
      for (int unsigned i = 0; i < pl; i += 8) begin
        for (int unsigned j = 0; j < 8; j++)
          word[8*j +: 8] = (i + j < pl) ? payload[i+j] : bfc_pkg::PAD_BYTE;
        r = '0;
        r.result_kind   = bfc_pkg::KIND_WRITE;
        r.write_address = faddr + i;
        r.write_data    = word;
        r.status        = bfc_pkg::ST_NONE;
        r.last          = 1'b0;
        pending.push_back(r);
        writes++;
      end
      st = bfc_pkg::ST_OK;
    end
    r = '0;
    r.result_kind = bfc_pkg::KIND_VERDICT;
    r.status      = st;
    r.last        = 1'b1;
    pending.push_back(r);
    verdicts[st]++;
    clear_frame();
  endfunction

  function void compare(string what, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, e, g);
    end
  endfunction

  function void match_result(bfc_pkg::out_t got);
    bfc_pkg::out_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none, got %h", $time, got);
      return;
    end
    e = pending.pop_front();
    compare("result_kind", 64'(e.result_kind), 64'(got.result_kind));
    compare("write_address", 64'(e.write_address), 64'(got.write_address));
    compare("write_data", e.write_data, got.write_data);
    compare("status", 64'(e.status), 64'(got.status));
    compare("last", 64'(e.last), 64'(got.last));
  endfunction
endclass

module tb;
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  bfc_pkg::in_t                   in_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  bfc_pkg::out_t                  out_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bfc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  frame_checker_model tracker;
  int          tx_idle_pct = 26;
  int          rx_idle_pct = 60;
  logic [31:0] cfg_app  = bfc_pkg::APP_START_RST;
  logic [32:0] cfg_fend = bfc_pkg::FLASH_END_RST;
  logic [7:0]  cfg_h0   = bfc_pkg::HEADER_FIRST_RST;
  logic [7:0]  cfg_h1   = bfc_pkg::HEADER_SECOND_RST;

  bootloader_frame_checker dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_i,
    .out_valid_o,
    .out_stall_i,
    .out_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // input transfer is noted before the output one of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.take_byte(in_i);
      if (out_valid_o && !out_stall_i) tracker.match_result(out_o);
    end
  end

  function automatic byte_q_t build_update_frame(logic [15:0] len, logic [31:0] addr,
                                                 int n_pay, bit bad_crc, int extra, int fill);
    byte_q_t     q;
    logic [15:0] c;
    q = {};
    q.push_back(cfg_h0);
    q.push_back(cfg_h1);
    q.push_back(len[7:0]);
    q.push_back(len[15:8]);
    for (int i = 0; i < 4; i++) q.push_back(addr[8*i +: 8]);
    for (int i = 0; i < n_pay; i++)
      q.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
    c = bfc_pkg::CRC_INIT;
    for (int i = 2; i < q.size(); i++) c = modbus_crc_step(c, q[i]);
    if (bad_crc) c ^= 16'(1) << $urandom_range(15);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    for (int i = 0; i < extra; i++) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 16);
    return $urandom_range(17, 48);
  endfunction

  function automatic logic [31:0] good_addr(int pl);
    longint unsigned lo, hi;
    int sel;
    lo = cfg_app;
    if (longint'(cfg_fend) < lo + pl) return $urandom;
    hi = longint'(cfg_fend) - pl;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    sel = $urandom_range(9);
    if (sel < 2) return lo[31:0];
    if (sel < 4) return hi[31:0];
    return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
  endfunction

  function automatic logic [31:0] bad_addr(int pl);
    longint unsigned v;
    if (cfg_app != 0 && $urandom_range(1) == 1) return cfg_app - 1 - ($urandom % cfg_app);
    v = (longint'(cfg_fend) + 1 > pl) ? longint'(cfg_fend) + 1 - pl : 0;
    v += $urandom_range(0, 63);
    if (v > 64'hFFFF_FFFF) return (cfg_app != 0) ? cfg_app - 1 : 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic byte_q_t random_frame();
    byte_q_t q;
    int kind, pl, cut, n;
    kind = $urandom_range(99);
    pl   = pick_len();
    if (kind < 55) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 0;
      q = build_update_frame(pl, good_addr(pl), pl, 0, n, -1);
    end else if (kind < 63) begin
      q = build_update_frame(0, bfc_pkg::END_ADDRESS, 0, 0, $urandom_range(0, 2), -1);
    end else if (kind < 71) begin
      q = build_update_frame(pl, good_addr(pl), pl, 1, 0, -1);
    end else if (kind < 78) begin
      q = build_update_frame(pl, bad_addr(pl), pl, 0, 0, -1);
    end else if (kind < 83) begin
      q = build_update_frame($urandom_range(bfc_pkg::MAX_PAYLOAD_DEF + 1, 65535), $urandom,
                             $urandom_range(0, 20), 0, 0, -1);
    end else if (kind < 90) begin
      q = build_update_frame(pl, good_addr(pl), pl, 0, 0, -1);
      cut = $urandom_range(1, q.size() - 1);
      q = q[0:cut-1];
    end else if (kind < 95) begin
      q = build_update_frame(pl, good_addr(pl), pl, 0, 0, -1);
      q[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    end else begin
      n = $urandom_range(1, 16);
      q = {};
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  task automatic send_byte(logic [7:0] b, bit last_byte);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= {b, last_byte};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame(byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // hold the sender off until every predicted result has been transferred
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [bfc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bfc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(logic [31:0] app, logic [32:0] fend, logic [7:0] h0, logic [7:0] h1);
    cfg_write(bfc_pkg::CFG_APP_START, {1'b0, app});
    cfg_write(bfc_pkg::CFG_FLASH_END, fend);
    cfg_write(bfc_pkg::CFG_HEADER_FIRST, 33'(h0));
    cfg_write(bfc_pkg::CFG_HEADER_SECOND, 33'(h1));
    cfg_app  = app;
    cfg_fend = fend;
    cfg_h0   = h0;
    cfg_h1   = h1;
  endtask

  task automatic directed_frames();
    byte_q_t q;
    // reset configuration
    q = build_update_frame(0, cfg_app, 0, 0, 0, -1);
    send_frame(q[0:0]);
    q = build_update_frame(4, cfg_app, 4, 0, 0, -1);
    send_frame(q[0:8]);
    send_frame(build_update_frame(0, cfg_app, 0, 0, 0, -1));
    send_frame(build_update_frame(1, cfg_app, 1, 0, 0, 8'h00));
    send_frame(build_update_frame(8, cfg_app + 8, 8, 0, 0, 8'hFF));
    send_frame(build_update_frame(9, 32'(cfg_fend - 9), 9, 0, 0, -1));
    send_frame(build_update_frame(4, cfg_app - 1, 4, 0, 0, -1));
    send_frame(build_update_frame(4, 32'(cfg_fend - 3), 4, 0, 0, -1));
    send_frame(build_update_frame(0, bfc_pkg::END_ADDRESS, 0, 0, 0, -1));
    send_frame(build_update_frame(0, bfc_pkg::END_ADDRESS, 0, 1, 0, -1));
    q = build_update_frame(2, cfg_app, 2, 0, 0, -1);
    q[0] ^= 8'h01;
    send_frame(q);
    q = build_update_frame(2, cfg_app, 2, 0, 0, -1);
    q[1] ^= 8'h80;
    send_frame(q);
    send_frame(build_update_frame(bfc_pkg::MAX_PAYLOAD_DEF + 1, cfg_app, 0, 0, 0, -1));
    send_frame(build_update_frame(16'hFFFF, cfg_app, 0, 0, 0, -1));
    q = build_update_frame(300, cfg_app, 0, 0, 0, -1);
    send_frame(q[0:4]);
    q = build_update_frame(5, cfg_app, 5, 0, 0, -1);
    send_frame(q[0:11]);
    send_frame(build_update_frame(3, cfg_app, 3, 0, 3, -1));
    send_frame(build_update_frame(9, cfg_app, 9, 1, 0, -1));

    drain();
    apply_config(32'h0, 33'h1_0000_0000, 8'h00, 8'hFF);
    send_frame(build_update_frame(1, 32'hFFFF_FFFF, 1, 0, 0, -1));
    send_frame(build_update_frame(8, 32'hFFFF_FFF8, 8, 0, 0, -1));
    send_frame(build_update_frame(8, 32'hFFFF_FFFC, 8, 0, 0, -1));
    send_frame(build_update_frame(3, 32'h0, 3, 0, 0, -1));
    send_frame(build_update_frame(0, bfc_pkg::END_ADDRESS, 0, 0, 0, -1));

    drain();
    apply_config(32'hFFFF_FFFF, 33'h0, 8'hFF, 8'h00);
    send_frame(build_update_frame(0, bfc_pkg::END_ADDRESS, 0, 0, 0, -1));
    send_frame(build_update_frame(1, bfc_pkg::END_ADDRESS, 1, 0, 0, -1));
    send_frame(build_update_frame(2, 32'h0, 2, 0, 0, -1));
  endtask

  task automatic random_phase(int phase);
    byte_q_t         q;
    int              nbytes, nframes;
    logic [31:0]     app;
    longint unsigned fend;
    drain();
    case (phase)
      0: apply_config(bfc_pkg::APP_START_RST, bfc_pkg::FLASH_END_RST,
                      bfc_pkg::HEADER_FIRST_RST, bfc_pkg::HEADER_SECOND_RST);
      1: begin
        app  = $urandom;
        fend = longint'(app) + $urandom_range(1024, 1 << 20);
        if (fend > 64'h1_0000_0000) fend = 64'h1_0000_0000;
        apply_config(app, fend[32:0], 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      default: apply_config(32'h0, 33'h1_0000_0000, 8'($urandom_range(255)),
                            8'($urandom_range(255)));
    endcase
    nbytes  = 0;
    nframes = 0;
    while (nbytes < 36 || nframes < 3) begin
      q = random_frame();
      send_frame(q);
      nbytes += q.size();
      nframes++;
      if ($urandom_range(24) == 0) drain();
    end
    drain();
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 26;
    rx_idle_pct = 60;
    directed_frames();
    random_phase(0);
    tx_idle_pct = 60;
    rx_idle_pct = 26;
    random_phase(1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(2);

    $display("Covered %0d bytes, %0d doubleword writes, extremes of all four registers.",
             tracker.bytes_taken, tracker.writes);
    $display("Verdicts: ok %0d, none %0d, length %0d, crc %0d, address %0d, done %0d.",
             tracker.verdicts[bfc_pkg::ST_OK], tracker.verdicts[bfc_pkg::ST_NONE],
             tracker.verdicts[bfc_pkg::ST_LEN], tracker.verdicts[bfc_pkg::ST_CRC],
             tracker.verdicts[bfc_pkg::ST_ADDR], tracker.verdicts[bfc_pkg::ST_DONE]);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: timed out, %0d results outstanding", $time, tracker.pending.size());
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/bfc_pkg.sv
hdl/bfc_ram.sv
hdl/bfc_rx.sv
hdl/bootloader_frame_checker.sv
verif/tb.sv
